// ----- design/mms_pkg.sv -----
// shared types and constants for the median and mode block
`default_nettype none
package mms_pkg;
    localparam int COUNT_BITS = 9;

    // controller to datapath commands
    typedef struct packed {
        logic store_beat;     // write the accepted sample into the store
        logic sort_start;     // begin a sort step
        logic scan_start;     // begin the linear scan
        logic clear_set;      // drop the set after a result
    } mms_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic sort_done;
        logic scan_done;
    } mms_stat_t;
endpackage
`default_nettype wire

// ----- design/mms_if.sv -----
// valid/ready stream channel with a generic payload
`default_nettype none
interface mms_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- design/median_and_mode_of_set.sv -----
// Median and mode of a set of signed samples. Samples are taken one per
// cycle into a store while the controller is in its load state; the marked
// last sample starts an insertion sort into a second memory at one
// compare/shift step per cycle, set by the single read port of that memory:
// each key is fetched in a load state and a key state, then shifts run one
// per cycle and the key is placed. A scan start step and a linear scan then
// give the doubled median and the smallest most-frequent value. The result
// beat holds until taken; no new sample is accepted between the last sample and that beat.
`default_nettype none
module median_and_mode_of_set #(
    parameter int MAX_ITEMS   = 256,
    parameter int SAMPLE_BITS = 16
) (
    input wire logic clk,
    input wire logic rst_n,
    mms_stream_if.sink   in_ch,
    mms_stream_if.source out_ch
);
    import mms_pkg::*;

    mms_cmd_t  cmd;
    mms_stat_t stat;

    mms_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_last(in_ch.data.last), .in_ready(in_ch.ready),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready),
        .cmd(cmd), .stat(stat)
    );

    mms_datapath #(.MAX_ITEMS(MAX_ITEMS), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd),
        .in_sample(in_ch.data.sample), .stat(stat),
        .median_twice(out_ch.data.median_twice),
        .mode_value(out_ch.data.mode_value),
        .mode_count(out_ch.data.mode_count),
        .has_mode(out_ch.data.has_mode),
        .item_count(out_ch.data.item_count),
        .overflowed(out_ch.data.overflowed)
    );

`ifndef SYNTH
    // no sample is taken while a result beat waits
    a_no_in_during_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> !in_ch.ready) else $error("input open during result");
    // a taken result beat drops valid next cycle
    a_out_once: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.ready |=> !out_ch.valid) else $error("result repeated");
`endif
endmodule
`default_nettype wire

// ----- design/mms_ram.sv -----
// generic ram with one write port and one registered read port
`default_nettype none
module mms_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ----- design/mms_datapath.sv -----
// store, sorted store, insertion sort and median/mode scan
`default_nettype none
module mms_datapath #(
    parameter int MAX_ITEMS   = 256,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire mms_pkg::mms_cmd_t            cmd,
    input  wire logic signed [SAMPLE_BITS-1:0] in_sample,
    output mms_pkg::mms_stat_t                stat,
    output logic signed [SAMPLE_BITS:0]       median_twice,
    output logic signed [SAMPLE_BITS-1:0]     mode_value,
    output logic [mms_pkg::COUNT_BITS-1:0]    mode_count,
    output logic                              has_mode,
    output logic [mms_pkg::COUNT_BITS-1:0]    item_count,
    output logic                              overflowed
);
    import mms_pkg::*;

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam logic [CW-1:0] FULL = CW'(MAX_ITEMS);

    // sorted store built in place by insertion, one compare/shift step per cycle:
    // fetch key, compare with slot j-1, shift it up or place key at j
    typedef enum logic [2:0] {
        DP_IDLE, DP_LOADKEY, DP_KEY, DP_CMP, DP_PLACE, DP_SCAN_RD, DP_SCAN
    } dp_state_t;

    dp_state_t              st_reg, st_next;
    logic [CW-1:0]          fill_reg, fill_next;
    logic                   ovf_reg, ovf_next;
    logic [CW-1:0]          i_reg, i_next;
    logic [CW-1:0]          j_reg, j_next;
    logic signed [SAMPLE_BITS-1:0] key_reg, key_next;
    logic signed [SAMPLE_BITS-1:0] prev_reg, prev_next;
    logic [CW-1:0]          run_reg, run_next, best_reg, best_next;
    logic signed [SAMPLE_BITS-1:0] bestv_reg, bestv_next;
    logic signed [SAMPLE_BITS:0]   med_reg, med_next;

    logic                   raw_we, srt_we;
    logic [AW-1:0]          raw_ra, srt_wa, srt_ra;
    logic [SAMPLE_BITS-1:0] raw_rd, srt_rd, srt_wd;
    logic signed [SAMPLE_BITS-1:0] srt_v;
    logic signed [SAMPLE_BITS:0]   v_ext;
    logic [CW-1:0]          mid_hi, mid_lo, scan_k, run_new;

    assign srt_v  = $signed(srt_rd);
    assign v_ext  = (SAMPLE_BITS+1)'(srt_v);
    assign mid_hi = fill_reg >> 1;
    assign mid_lo = fill_reg[0] ? mid_hi : mid_hi - CW'(1);

    // scan: index of the element whose data arrives this cycle, and its run length
    assign scan_k  = i_reg - CW'(1);
    assign run_new = (scan_k == '0 || srt_v != prev_reg) ? CW'(1) : run_reg + CW'(1);

    mms_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_ITEMS)) u_raw (
        .clk(clk), .we(raw_we), .waddr(fill_reg[AW-1:0]), .wdata(in_sample),
        .raddr(raw_ra), .rdata(raw_rd)
    );
    mms_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_ITEMS)) u_srt (
        .clk(clk), .we(srt_we), .waddr(srt_wa), .wdata(srt_wd),
        .raddr(srt_ra), .rdata(srt_rd)
    );

    assign raw_we = cmd.store_beat && (fill_reg < FULL);
    assign raw_ra = i_reg[AW-1:0];

    // sort and scan sequencing
    always_comb
    begin
        st_next    = st_reg;
        fill_next  = fill_reg;
        ovf_next   = ovf_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        key_next   = key_reg;
        prev_next  = prev_reg;
        run_next   = run_reg;
        best_next  = best_reg;
        bestv_next = bestv_reg;
        med_next   = med_reg;
        srt_we     = 1'b0;
        srt_wa     = j_reg[AW-1:0];
        srt_wd     = key_reg;
        srt_ra     = j_reg[AW-1:0];
        stat       = '0;
        if (cmd.store_beat)
        begin
            if (fill_reg < FULL) fill_next = fill_reg + CW'(1);
            else                 ovf_next  = 1'b1;
        end
        if (cmd.clear_set)
        begin
            fill_next = '0;
            ovf_next  = 1'b0;
        end
        unique case (st_reg)
            DP_IDLE:
            begin
                if (cmd.sort_start)
                begin
                    i_next  = '0;
                    st_next = DP_LOADKEY;
                end
                else if (cmd.scan_start)
                begin
                    i_next  = '0;
                    st_next = DP_SCAN_RD;
                end
            end
            DP_LOADKEY:
            begin
                if (i_reg == fill_reg)
                begin
                    stat.sort_done = 1'b1;
                    st_next        = DP_IDLE;
                end
                else
                begin
                    j_next  = i_reg;
                    st_next = DP_KEY;
                end
            end
            DP_KEY:
            begin
                key_next = $signed(raw_rd);
                if (j_reg == '0)
                begin
                    srt_we  = 1'b1;
                    srt_wd  = raw_rd;
                    i_next  = i_reg + CW'(1);
                    st_next = DP_LOADKEY;
                end
                else
                begin
                    srt_ra  = AW'(j_reg - CW'(1));
                    st_next = DP_CMP;
                end
            end
            DP_CMP:
            begin
                if (srt_v > key_reg)
                begin
                    // shift slot j-1 up into slot j
                    srt_we = 1'b1;
                    srt_wd = srt_rd;
                    j_next = j_reg - CW'(1);
                    if (j_reg == CW'(1))
                    begin
                        st_next = DP_PLACE;
                    end
                    else
                    begin
                        srt_ra = AW'(j_reg - CW'(2));
                    end
                end
                else
                begin
                    srt_we  = 1'b1;
                    i_next  = i_reg + CW'(1);
                    st_next = DP_LOADKEY;
                end
            end
            DP_PLACE:
            begin
                // key goes to slot 0
                srt_we  = 1'b1;
                i_next  = i_reg + CW'(1);
                st_next = DP_LOADKEY;
            end
            DP_SCAN_RD:
            begin
                srt_ra    = i_reg[AW-1:0];
                i_next    = i_reg + CW'(1);
                run_next  = '0;
                best_next = '0;
                st_next   = DP_SCAN;
            end
            DP_SCAN:
            begin
                srt_ra = i_reg[AW-1:0];
                if (scan_k == mid_lo)
                begin
                    med_next = v_ext;
                end
                if (scan_k == mid_hi)
                begin
                    med_next = ((scan_k == mid_lo) ? v_ext : med_reg) + v_ext;
                end
                run_next = run_new;
                if (run_new > best_reg)
                begin
                    best_next  = run_new;
                    bestv_next = srt_v;
                end
                prev_next = srt_v;
                i_next    = i_reg + CW'(1);
                if (i_reg == fill_reg)
                begin
                    stat.scan_done = 1'b1;
                    st_next        = DP_IDLE;
                end
            end
            default: st_next = DP_IDLE;
        endcase
    end

    // state and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= DP_IDLE;
            fill_reg  <= '0;
            ovf_reg   <= 1'b0;
            i_reg     <= '0;
            j_reg     <= '0;
            key_reg   <= '0;
            prev_reg  <= '0;
            run_reg   <= '0;
            best_reg  <= '0;
            bestv_reg <= '0;
            med_reg   <= '0;
        end
        else
        begin
            st_reg    <= st_next;
            fill_reg  <= fill_next;
            ovf_reg   <= ovf_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            key_reg   <= key_next;
            prev_reg  <= prev_next;
            run_reg   <= run_next;
            best_reg  <= best_next;
            bestv_reg <= bestv_next;
            med_reg   <= med_next;
        end
    end

    // results
    assign median_twice = med_reg;
    assign has_mode     = best_reg > CW'(1);
    assign mode_value   = has_mode ? bestv_reg : '0;
    assign mode_count   = has_mode ? COUNT_BITS'(best_reg) : COUNT_BITS'(1);
    assign item_count   = COUNT_BITS'(fill_reg);
    assign overflowed   = ovf_reg;
endmodule
`default_nettype wire

// ----- design/mms_ctrl.sv -----
// controller sequencing load, sort, scan and result beat
`default_nettype none
module mms_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               in_last,
    output logic                    in_ready,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output mms_pkg::mms_cmd_t       cmd,
    input  wire mms_pkg::mms_stat_t stat
);
    import mms_pkg::*;

    typedef enum logic [2:0] {
        S_LOAD, S_SORT, S_SCAN_GO, S_SCAN, S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   ov_reg, ov_next;

    assign in_ready  = (state_reg == S_LOAD);
    assign out_valid = ov_reg;

    always_comb
    begin
        state_next     = state_reg;
        ov_next        = ov_reg;
        cmd            = '0;
        cmd.store_beat = in_valid && in_ready;
        unique case (state_reg)
            S_LOAD:
            begin
                if (in_valid && in_last)
                begin
                    cmd.sort_start = 1'b1;
                    state_next     = S_SORT;
                end
            end
            S_SORT:
            begin
                if (stat.sort_done)
                begin
                    state_next = S_SCAN_GO;
                end
            end
            // datapath is idle again, start the scan
            S_SCAN_GO:
            begin
                cmd.scan_start = 1'b1;
                state_next     = S_SCAN;
            end
            S_SCAN:
            begin
                if (stat.scan_done)
                begin
                    ov_next    = 1'b1;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    ov_next       = 1'b0;
                    cmd.clear_set = 1'b1;
                    state_next    = S_LOAD;
                end
            end
            default: state_next = S_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end
endmodule
`default_nettype wire
